>>> hdl/jhe_pkg.sv
`default_nettype none
package jhe_pkg;

	// huffman table selectors
	typedef enum logic [1:0] {
		TBL_DCL = 2'd0,
		TBL_ACL = 2'd1,
		TBL_DCC = 2'd2,
		TBL_ACC = 2'd3
	} tbl_sel_t;

	localparam logic [7:0] SYM_ZRL = 8'hF0;
	localparam logic [7:0] SYM_EOB = 8'h00;
	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic signed [12:0] DC_MAX = 13'sd2047;
	localparam logic signed [11:0] AC_MAX = 12'sd1023;
	localparam logic [5:0] RUN_MAX = 6'd63;
	localparam logic [5:0] POS_LAST = 6'd63;
	localparam logic [1:0] COMP_NONE = 2'd3;

	typedef struct packed {
		logic [4:0]  size;
		logic [15:0] code;
	} huff_ent_t;

	typedef huff_ent_t [255:0] huff_rom_t;

	// packer command from the sequencer
	typedef struct packed {
		logic        put;
		logic        fin;
		logic [15:0] code;
		logic [4:0]  len;
	} pk_cmd_t;

	// packer status back to the sequencer
	typedef struct packed {
		logic       drained;
		logic [2:0] cnt;
		logic       hold_v;
		logic       fin_done;
	} pk_stat_t;

	localparam logic [0:16][7:0] DCL_LEN = {8'd0, 8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [0:16][7:0] DCC_LEN = {8'd0, 8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
	localparam logic [0:16][7:0] ACL_LEN = {8'd0, 8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4,
		8'd3, 8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d};
	localparam logic [0:16][7:0] ACC_LEN = {8'd0, 8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3,
		8'd4, 8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77};

	localparam logic [0:161][7:0] DC_SYMS = {8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
		8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, {150{8'h00}}};

	localparam logic [0:161][7:0] ACL_SYMS = {
		8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41, 8'h06,
		8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
		8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24, 8'h33, 8'h62, 8'h72,
		8'h82, 8'h09, 8'h0a, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
		8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44, 8'h45,
		8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
		8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75,
		8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
		8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3,
		8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
		8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9,
		8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
		8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf1, 8'hf2, 8'hf3, 8'hf4,
		8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa};

	localparam logic [0:161][7:0] ACC_SYMS = {
		8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21, 8'h31, 8'h06, 8'h12, 8'h41,
		8'h51, 8'h07, 8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
		8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0, 8'h15, 8'h62, 8'h72, 8'hd1,
		8'h0a, 8'h16, 8'h24, 8'h34, 8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
		8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44,
		8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
		8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74,
		8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
		8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
		8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
		8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
		8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
		8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf2, 8'hf3, 8'hf4,
		8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa};

	// canonical code assignment, evaluated at elaboration
	function automatic huff_rom_t build_rom(input logic [0:16][7:0] lens,
			input logic [0:161][7:0] syms, input int nsyms);
		huff_rom_t   rom;
		logic [16:0] code;
		int          k;
		rom  = '0;
		code = '0;
		k    = 0;
		for (int l = 1; l <= 16; l++) begin
			for (int i = 0; i < int'(lens[l]); i++) begin
				if (k < nsyms) begin
					rom[syms[k]] = {5'(l), code[15:0]};
					code = code + 17'd1;
					k = k + 1;
				end
			end
			code = code << 1;
		end
		return rom;
	endfunction

	localparam huff_rom_t ROM_DCL = build_rom(DCL_LEN, DC_SYMS, 12);
	localparam huff_rom_t ROM_ACL = build_rom(ACL_LEN, ACL_SYMS, 162);
	localparam huff_rom_t ROM_DCC = build_rom(DCC_LEN, DC_SYMS, 12);
	localparam huff_rom_t ROM_ACC = build_rom(ACC_LEN, ACC_SYMS, 162);

	function automatic huff_ent_t huff_lookup(input tbl_sel_t t, input logic [7:0] sym);
		huff_ent_t e;
		unique case (t)
			TBL_DCL: e = ROM_DCL[sym];
			TBL_ACL: e = ROM_ACL[sym];
			TBL_DCC: e = ROM_DCC[sym];
			TBL_ACC: e = ROM_ACC[sym];
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

>>> hdl/jhe_bitpack.sv
`default_nettype none
module jhe_bitpack (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire jhe_pkg::pk_cmd_t cmd,
	output jhe_pkg::pk_stat_t     stat,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [7:0]            m_axis_tdata,   // out_byte
	output logic                  m_axis_tlast    // last_of_run
);

	logic [22:0] acc_q;
	logic [4:0]  cnt_q;
	logic        stuff_q;
	logic [7:0]  hold_q;
	logic        hold_v_q;
	logic        drained;
	logic        out_free;
	logic [7:0]  next_byte;
	logic        produce;
	logic        fin_move;

	// one byte a cycle through the shifter, unless a stalled output holds the held byte
	assign drained   = (cnt_q < 5'd8) && !stuff_q;
	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign next_byte = stuff_q ? 8'h00 : 8'(acc_q >> (cnt_q - 5'd8));
	assign produce   = !drained && (!hold_v_q || out_free);
	assign fin_move  = cmd.fin && drained && hold_v_q && out_free;

	assign stat = '{
		drained:  drained,
		cnt:      cnt_q[2:0],
		hold_v:   hold_v_q,
		fin_done: cmd.fin && drained && (!hold_v_q || out_free)
	};

	// accumulator, held byte and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			stuff_q       <= 1'b0;
			hold_v_q      <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			m_axis_tvalid <= (produce && hold_v_q) || fin_move ||
				(m_axis_tvalid && !m_axis_tready);
			if (cmd.put && drained) begin
				acc_q <= 23'((acc_q << cmd.len) | {7'd0, cmd.code});
				cnt_q <= cnt_q + cmd.len;
			end
			if (produce) begin
				if (hold_v_q) begin
					m_axis_tdata <= hold_q;
					m_axis_tlast <= 1'b0;
				end
				hold_q   <= next_byte;
				hold_v_q <= 1'b1;
				if (stuff_q) begin
					stuff_q <= 1'b0;
				end else begin
					cnt_q   <= cnt_q - 5'd8;
					stuff_q <= (next_byte == jhe_pkg::BYTE_FF);
				end
			end
			if (fin_move) begin
				m_axis_tdata <= hold_q;
				m_axis_tlast <= 1'b1;
				hold_v_q     <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/jpeg_huffman_block_encoder_unit.sv
`default_nettype none
// channel  | dir | tdata                              | tuser                     | tlast
// s_axis   | in  | [11:0] coefficient, [17:12] zz_pos | [1:0] component, [2] eos  | -
// m_axis   | out | [7:0] out_byte                     | -                         | last_of_run
//
// one item at a time: the item is accepted and decoded, a coded value is sized, then each code
// word is put into the packer and each produced byte (stuffing included) is shifted out by the
// single byte shifter in the packer, and the item is closed.
// arst_n clears predictors, zero run, pending bits and all handshake state.
// a stalled m_axis holds the packer, which holds the sequencer.
module jpeg_huffman_block_encoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // coefficient, zz_position, zero fill
	input  wire logic [2:0]  s_axis_tuser,   // component, end_of_scan
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // out_byte
	output logic             m_axis_tlast    // last_of_run
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_CAT, ST_ZRL, ST_SYM, ST_VAL, ST_EOB, ST_PAD, ST_FIN
	} state_t;

	state_t                   st_q;
	logic signed [11:0]       coef_q;
	logic [5:0]               pos_q;
	logic [1:0]               comp_q;
	logic                     eos_q;
	logic signed [11:0]       pred_q [0:2];
	logic [5:0]               zr_q;
	logic signed [11:0]       val_q;
	logic [3:0]               cat_q;
	logic [15:0]              bits_q;
	logic                     is_dc_q;
	jhe_pkg::pk_cmd_t         pk_cmd;
	jhe_pkg::pk_stat_t        pk_st;
	jhe_pkg::tbl_sel_t        tsel;
	logic [7:0]               sym;
	jhe_pkg::huff_ent_t       ent;
	logic signed [12:0]       diff;
	logic signed [11:0]       dc_cl;
	logic signed [11:0]       ac_cl;
	logic [5:0]               zr_inc;
	logic [10:0]              mag;
	logic [3:0]               cat;
	logic [11:0]              wval;
	logic                     put_st;

	assign s_axis_tready = (st_q == ST_IDLE);

	// dc difference and clamps
	always_comb begin
		diff = 13'(coef_q) - 13'(pred_q[comp_q]);
		if (diff > jhe_pkg::DC_MAX) dc_cl = 12'(jhe_pkg::DC_MAX);
		else if (diff < -jhe_pkg::DC_MAX) dc_cl = 12'(-jhe_pkg::DC_MAX);
		else dc_cl = diff[11:0];
		if (coef_q > jhe_pkg::AC_MAX) ac_cl = jhe_pkg::AC_MAX;
		else if (coef_q < -jhe_pkg::AC_MAX) ac_cl = -jhe_pkg::AC_MAX;
		else ac_cl = coef_q;
		zr_inc = (zr_q == jhe_pkg::RUN_MAX) ? zr_q : zr_q + 6'd1;
	end

	// size category and value bits
	always_comb begin
		mag = val_q[11] ? 11'(-val_q) : val_q[10:0];
		cat = '0;
		for (int i = 0; i < 11; i++) begin
			if (mag[i]) cat = 4'(i + 1);
		end
		wval = val_q[11] ? 12'(val_q - 12'sd1) : 12'(val_q);
	end

	// symbol selection and table read
	always_comb begin
		if (is_dc_q) tsel = (comp_q == 2'd0) ? jhe_pkg::TBL_DCL : jhe_pkg::TBL_DCC;
		else tsel = (comp_q == 2'd0) ? jhe_pkg::TBL_ACL : jhe_pkg::TBL_ACC;
		unique case (st_q)
			ST_ZRL:  sym = jhe_pkg::SYM_ZRL;
			ST_EOB:  sym = jhe_pkg::SYM_EOB;
			default: sym = is_dc_q ? {4'd0, cat_q} : {zr_q[3:0], cat_q};
		endcase
		ent = jhe_pkg::huff_lookup(tsel, sym);
	end

	// packer command
	always_comb begin
		put_st = (st_q == ST_ZRL) || (st_q == ST_SYM) || (st_q == ST_VAL) ||
			(st_q == ST_EOB) || ((st_q == ST_PAD) && (pk_st.cnt != 3'd0));
		pk_cmd.put = put_st && pk_st.drained;
		pk_cmd.fin = (st_q == ST_FIN);
		unique case (st_q)
			ST_VAL: begin
				pk_cmd.code = bits_q;
				pk_cmd.len  = {1'b0, cat_q};
			end
			ST_PAD: begin
				pk_cmd.code = {8'd0, jhe_pkg::BYTE_FF >> pk_st.cnt};
				pk_cmd.len  = 5'd8 - {2'd0, pk_st.cnt};
			end
			default: begin
				pk_cmd.code = ent.code;
				pk_cmd.len  = ent.size;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			zr_q    <= '0;
			pred_q  <= '{default: '0};
			coef_q  <= '0;
			pos_q   <= '0;
			comp_q  <= '0;
			eos_q   <= 1'b0;
			val_q   <= '0;
			cat_q   <= '0;
			bits_q  <= '0;
			is_dc_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						coef_q <= s_axis_tdata[11:0];
						pos_q  <= s_axis_tdata[17:12];
						comp_q <= s_axis_tuser[1:0];
						eos_q  <= s_axis_tuser[2];
						st_q   <= ST_PREP;
					end
				end
				ST_PREP: begin
					if (eos_q) begin
						st_q <= ST_PAD;
					end else if (comp_q == jhe_pkg::COMP_NONE) begin
						st_q <= ST_FIN;
					end else if (pos_q == 6'd0) begin
						val_q          <= dc_cl;
						pred_q[comp_q] <= pred_q[comp_q] + dc_cl;
						zr_q           <= '0;
						is_dc_q        <= 1'b1;
						st_q           <= ST_CAT;
					end else if (ac_cl == 12'sd0) begin
						is_dc_q <= 1'b0;
						if (pos_q == jhe_pkg::POS_LAST) begin
							zr_q <= '0;
							st_q <= ST_EOB;
						end else begin
							zr_q <= zr_inc;
							st_q <= ST_FIN;
						end
					end else begin
						val_q   <= ac_cl;
						is_dc_q <= 1'b0;
						st_q    <= ST_CAT;
					end
				end
				ST_CAT: begin
					cat_q  <= cat;
					bits_q <= 16'(wval & ~(12'hFFF << cat));
					st_q   <= (!is_dc_q && zr_q > 6'd15) ? ST_ZRL : ST_SYM;
				end
				ST_ZRL: begin
					if (pk_st.drained) begin
						zr_q <= zr_q - 6'd16;
						if (zr_q < 6'd32) st_q <= ST_SYM;
					end
				end
				ST_SYM: begin
					if (pk_st.drained) st_q <= ST_VAL;
				end
				ST_VAL: begin
					if (pk_st.drained) begin
						zr_q <= '0;
						st_q <= ST_FIN;
					end
				end
				ST_EOB: begin
					if (pk_st.drained) st_q <= ST_FIN;
				end
				ST_PAD: begin
					if (pk_st.drained) st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (pk_st.fin_done) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	jhe_bitpack u_pack (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (pk_cmd),
		.stat          (pk_st),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// a new item finds no leftover byte in the packer
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (pk_st.drained && !pk_st.hold_v))
		else $error("packer not empty while idle");

	// code words only enter a drained packer
	a_put_drained: assert property (@(posedge clk) disable iff (!arst_n)
		pk_cmd.put |-> pk_st.drained)
		else $error("put into busy packer");

	// closing an item returns to idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FIN && pk_st.fin_done) |=> s_axis_tready)
		else $error("close did not return to idle");

endmodule
`default_nettype wire
